// File: rtl/nrpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrpe_pkg
// Constants and helpers for the RMC position extractor: character codes,
// header text, comma positions of the captured fields and report codes.
// ----------------------------------------------------------------------------
package nrpe_pkg;

	localparam int MAX_CHARS = 16;
	localparam int OUT_W     = 288;

	localparam logic [7:0] LINE_FEED = 8'h0A;
	localparam logic [7:0] COMMA     = 8'h2C;
	localparam logic [7:0] STATUS_A  = 8'h41;
	localparam logic [7:0] STATUS_V  = 8'h56;

	localparam logic [2:0] HEADER_LEN = 3'd6;
	localparam logic [3:0] MIN_COMMAS = 4'd11;
	localparam logic [3:0] COMMA_MAX  = 4'd15;

	localparam logic [3:0] FLD_STATUS = 4'd2;
	localparam logic [3:0] FLD_LAT    = 4'd3;
	localparam logic [3:0] FLD_NS     = 4'd4;
	localparam logic [3:0] FLD_LON    = 4'd5;
	localparam logic [3:0] FLD_EW     = 4'd6;

	localparam logic [2:0] RPT_OTHER     = 3'd0;
	localparam logic [2:0] RPT_FIX       = 3'd1;
	localparam logic [2:0] RPT_VOID      = 3'd2;
	localparam logic [2:0] RPT_UNKNOWN   = 3'd3;
	localparam logic [2:0] RPT_MALFORMED = 3'd4;

	function automatic logic [7:0] header_char(input logic [2:0] pos);
		logic [7:0] ch;
		unique case (pos)
			3'd0: ch = 8'h24;
			3'd1: ch = 8'h47;
			3'd2: ch = 8'h50;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h4D;
			3'd5: ch = 8'h43;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

// File: rtl/nmea_rmc_position_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nmea_rmc_position_extractor
// Parses $GPRMC lines from a byte stream and keeps the last valid position.
// ----------------------------------------------------------------------------
// The slave channel takes one received byte per word. Every line feed yields
// one report word on the master channel; other bytes yield none. A report
// carries the line's status code, the fix flag and the stored latitude and
// longitude text with their lengths and hemisphere letters.
// A byte is registered on acceptance and processed from the input register,
// and the report word for a line feed is registered when it is processed.
// One byte is accepted every cycle while no line feed is held back; the line
// state and the stored position are updated by logic behind the input register.
// While a report waits for the receiver, ordinary bytes keep flowing; a
// further line feed is held in the input register until the report is taken.
// Reset clears the line state, the stored lengths, the letters and the fix
// flag, so the first report before any fix shows empty fields.
// ----------------------------------------------------------------------------
module nmea_rmc_position_extractor #(
	parameter int FIELD_CHARS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// Fields: rx_byte.
	input  logic [7:0]                 s_axis_tdata,
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// Fields: line_status, fix_valid, lat_high_chars, lat_low_chars, lat_length,
	// lat_hemisphere, lon_high_chars, lon_low_chars, lon_length, lon_hemisphere,
	// padding.
	output logic [nrpe_pkg::OUT_W-1:0] m_axis_tdata
);
	import nrpe_pkg::*;

	localparam int         IDX_W   = (FIELD_CHARS > 1) ? $clog2(FIELD_CHARS) : 1;
	localparam logic [4:0] LEN_CAP = 5'(FIELD_CHARS);

	logic       valid_s1;
	logic [7:0] byte_s1;

	logic [2:0] hdr_pos_q;
	logic       hdr_miss_q;
	logic [3:0] comma_cnt_q;
	logic [7:0] stat_letter_q;
	logic [7:0] line_lat_q [FIELD_CHARS];
	logic [7:0] line_lon_q [FIELD_CHARS];
	logic [4:0] line_lat_len_q;
	logic [4:0] line_lon_len_q;
	logic [7:0] line_ns_q;
	logic [7:0] line_ew_q;

	logic [7:0] kept_lat_q [FIELD_CHARS];
	logic [7:0] kept_lon_q [FIELD_CHARS];
	logic [4:0] kept_lat_len_q;
	logic [4:0] kept_lon_len_q;
	logic [7:0] kept_ns_q;
	logic [7:0] kept_ew_q;
	logic       fix_valid_q;

	logic [2:0] status_q;
	logic       out_valid_q;

	logic       is_lf;
	logic       step;
	logic       hdr_done;
	logic       field_byte;
	logic       commit;
	logic [2:0] line_code;
	logic       take_lat;
	logic       take_lon;

	logic [127:0] lat_chars;
	logic [127:0] lon_chars;

	assign is_lf         = (byte_s1 == LINE_FEED);
	assign step          = valid_s1 && (!is_lf || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || step;
	assign hdr_done      = (hdr_pos_q == HEADER_LEN);
	assign field_byte    = step && !is_lf && hdr_done && (byte_s1 != COMMA);
	assign commit        = step && is_lf;
	assign take_lat      = field_byte && (comma_cnt_q == FLD_LAT) && (line_lat_len_q < LEN_CAP);
	assign take_lon      = field_byte && (comma_cnt_q == FLD_LON) && (line_lon_len_q < LEN_CAP);

	always_comb begin
		priority if (!hdr_done || hdr_miss_q) begin
			line_code = RPT_OTHER;
		end else if (comma_cnt_q < MIN_COMMAS) begin
			line_code = RPT_MALFORMED;
		end else if (stat_letter_q == STATUS_A) begin
			line_code = RPT_FIX;
		end else if (stat_letter_q == STATUS_V) begin
			line_code = RPT_VOID;
		end else begin
			line_code = RPT_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_pos_q      <= '0;
			hdr_miss_q     <= 1'b0;
			comma_cnt_q    <= '0;
			stat_letter_q  <= '0;
			line_lat_len_q <= '0;
			line_lon_len_q <= '0;
			line_ns_q      <= '0;
			line_ew_q      <= '0;
		end else if (commit) begin
			hdr_pos_q      <= '0;
			hdr_miss_q     <= 1'b0;
			comma_cnt_q    <= '0;
			stat_letter_q  <= '0;
			line_lat_len_q <= '0;
			line_lon_len_q <= '0;
			line_ns_q      <= '0;
			line_ew_q      <= '0;
		end else if (step) begin
			if (!hdr_done) begin
				if (byte_s1 != header_char(hdr_pos_q)) begin
					hdr_miss_q <= 1'b1;
				end
				hdr_pos_q <= hdr_pos_q + 3'd1;
			end else if (byte_s1 == COMMA) begin
				if (comma_cnt_q != COMMA_MAX) begin
					comma_cnt_q <= comma_cnt_q + 4'd1;
				end
			end
			if (field_byte && comma_cnt_q == FLD_STATUS && stat_letter_q == 8'h00) begin
				stat_letter_q <= byte_s1;
			end
			if (field_byte && comma_cnt_q == FLD_NS && line_ns_q == 8'h00) begin
				line_ns_q <= byte_s1;
			end
			if (field_byte && comma_cnt_q == FLD_EW && line_ew_q == 8'h00) begin
				line_ew_q <= byte_s1;
			end
			if (take_lat) begin
				line_lat_len_q <= line_lat_len_q + 5'd1;
			end
			if (take_lon) begin
				line_lon_len_q <= line_lon_len_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_lat) begin
			line_lat_q[line_lat_len_q[IDX_W-1:0]] <= byte_s1;
		end
		if (take_lon) begin
			line_lon_q[line_lon_len_q[IDX_W-1:0]] <= byte_s1;
		end
		if (commit && line_code == RPT_FIX) begin
			kept_lat_q <= line_lat_q;
			kept_lon_q <= line_lon_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_lat_len_q <= '0;
			kept_lon_len_q <= '0;
			kept_ns_q      <= '0;
			kept_ew_q      <= '0;
			fix_valid_q    <= 1'b0;
			status_q       <= RPT_OTHER;
			out_valid_q    <= 1'b0;
		end else begin
			if (commit) begin
				status_q    <= line_code;
				out_valid_q <= 1'b1;
				if (line_code == RPT_FIX) begin
					kept_lat_len_q <= line_lat_len_q;
					kept_lon_len_q <= line_lon_len_q;
					kept_ns_q      <= line_ns_q;
					kept_ew_q      <= line_ew_q;
					fix_valid_q    <= 1'b1;
				end else if (line_code == RPT_VOID) begin
					fix_valid_q <= 1'b0;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	for (genvar g = 0; g < MAX_CHARS; g++) begin : g_chars
		if (g < FIELD_CHARS) begin : g_kept
			assign lat_chars[127-8*g -: 8] =
				(5'(g) < kept_lat_len_q) ? kept_lat_q[g] : 8'h00;
			assign lon_chars[127-8*g -: 8] =
				(5'(g) < kept_lon_len_q) ? kept_lon_q[g] : 8'h00;
		end else begin : g_none
			assign lat_chars[127-8*g -: 8] = 8'h00;
			assign lon_chars[127-8*g -: 8] = 8'h00;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, kept_ew_q, kept_lon_len_q, lon_chars[63:0], lon_chars[127:64],
		kept_ns_q, kept_lat_len_q, lat_chars[63:0], lat_chars[127:64], fix_valid_q, status_q};

endmodule

// File: tb/tb_nmea_rmc_position_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nmea_rmc_position_extractor
// Self-checking bench for the RMC position extractor. Byte streams made of
// directed lines and random sentences are driven into the slave channel.
// A predictor follows each accepted byte and keeps its own copy of the line
// and stored position, and every report word on the master channel is
// compared field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module tb_nmea_rmc_position_extractor;

	import nrpe_pkg::*;

	localparam int    FIELD_CHARS = 16;
	localparam string RMC_HEADER  = "$GPRMC";
	localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;

	// Report word as carried on m_axis_tdata, top field first.
	typedef struct packed {
		logic [1:0]  pad;
		logic [7:0]  lon_hemisphere;
		logic [4:0]  lon_length;
		logic [63:0] lon_low_chars;
		logic [63:0] lon_high_chars;
		logic [7:0]  lat_hemisphere;
		logic [4:0]  lat_length;
		logic [63:0] lat_low_chars;
		logic [63:0] lat_high_chars;
		logic        fix_valid;
		logic [2:0]  line_status;
	} rmc_report_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// Fields: rx_byte.
	logic [7:0]           s_axis_tdata  = 8'h00;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// Fields: line_status, fix_valid, lat_high_chars, lat_low_chars, lat_length,
	// lat_hemisphere, lon_high_chars, lon_low_chars, lon_length, lon_hemisphere,
	// padding.
	logic [OUT_W-1:0]     m_axis_tdata;

	logic [7:0]  rx_bytes_q [$];
	rmc_report_t rmc_reports_q [$];
	int          send_idle_pct   = 0;
	int          recv_idle_pct   = 0;
	int          mismatch_count  = 0;
	int          bytes_built     = 0;
	int          bytes_accepted  = 0;
	int          reports_checked = 0;
	int          status_tally [5] = '{default: 0};
	rmc_report_t got_rep;
	rmc_report_t want_rep;

	// Line state of the predictor.
	int          hdr_pos    = 0;
	logic        hdr_bad    = 1'b0;
	logic [3:0]  comma_cnt  = '0;
	logic [7:0]  status_ch  = '0;
	logic [7:0]  lat_buf [16];
	logic [7:0]  lon_buf [16];
	int          lat_n      = 0;
	int          lon_n      = 0;
	logic [7:0]  ns_ch      = '0;
	logic [7:0]  ew_ch      = '0;

	// Stored position of the predictor.
	logic [7:0]  kept_lat [16] = '{default: 8'h00};
	logic [7:0]  kept_lon [16] = '{default: 8'h00};
	int          kept_lat_n  = 0;
	int          kept_lon_n  = 0;
	logic [7:0]  kept_ns     = '0;
	logic [7:0]  kept_ew     = '0;
	logic        fix_flag    = 1'b0;

	nmea_rmc_position_extractor #(
		.FIELD_CHARS(FIELD_CHARS)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic logic [63:0] pack_chars(input logic [7:0] chars [16], input int len,
			input int first);
		logic [63:0] packed_word;
		packed_word = '0;
		for (int i = 0; i < 8; i++) begin
			if (first + i < len)
				packed_word[63 - 8 * i -: 8] = chars[first + i];
		end
		return packed_word;
	endfunction

	task automatic nmea_track_byte(input logic [7:0] ch);
		rmc_report_t rep;
		logic [2:0]  code;
		if (ch != LINE_FEED) begin
			if (hdr_pos < HEADER_LEN) begin
				if (ch != RMC_HEADER[hdr_pos])
					hdr_bad = 1'b1;
				hdr_pos++;
			end else if (ch == COMMA) begin
				if (comma_cnt < COMMA_MAX)
					comma_cnt++;
			end else begin
				case (comma_cnt)
					FLD_STATUS: begin
						if (status_ch == 8'h00)
							status_ch = ch;
					end
					FLD_LAT: begin
						if (lat_n < FIELD_CHARS) begin
							lat_buf[lat_n] = ch;
							lat_n++;
						end
					end
					FLD_NS: begin
						if (ns_ch == 8'h00)
							ns_ch = ch;
					end
					FLD_LON: begin
						if (lon_n < FIELD_CHARS) begin
							lon_buf[lon_n] = ch;
							lon_n++;
						end
					end
					FLD_EW: begin
						if (ew_ch == 8'h00)
							ew_ch = ch;
					end
					default: ;
				endcase
			end
			return;
		end
		if (hdr_pos < HEADER_LEN || hdr_bad) begin
			code = RPT_OTHER;
		end else if (comma_cnt < MIN_COMMAS) begin
			code = RPT_MALFORMED;
		end else if (status_ch == STATUS_A) begin
			kept_lat   = lat_buf;
			kept_lon   = lon_buf;
			kept_lat_n = lat_n;
			kept_lon_n = lon_n;
			kept_ns    = ns_ch;
			kept_ew    = ew_ch;
			fix_flag   = 1'b1;
			code       = RPT_FIX;
		end else if (status_ch == STATUS_V) begin
			fix_flag = 1'b0;
			code     = RPT_VOID;
		end else begin
			code = RPT_UNKNOWN;
		end
		rep.pad            = '0;
		rep.line_status    = code;
		rep.fix_valid      = fix_flag;
		rep.lat_high_chars = pack_chars(kept_lat, kept_lat_n, 0);
		rep.lat_low_chars  = pack_chars(kept_lat, kept_lat_n, 8);
		rep.lat_length     = 5'(kept_lat_n);
		rep.lat_hemisphere = kept_ns;
		rep.lon_high_chars = pack_chars(kept_lon, kept_lon_n, 0);
		rep.lon_low_chars  = pack_chars(kept_lon, kept_lon_n, 8);
		rep.lon_length     = 5'(kept_lon_n);
		rep.lon_hemisphere = kept_ew;
		rmc_reports_q.push_back(rep);
		status_tally[code]++;
		hdr_pos   = 0;
		hdr_bad   = 1'b0;
		comma_cnt = '0;
		status_ch = '0;
		lat_n     = 0;
		lon_n     = 0;
		ns_ch     = '0;
		ew_ch     = '0;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'h00;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				nmea_track_byte(s_axis_tdata);
				bytes_accepted++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= rx_bytes_q.pop_front();
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (rmc_reports_q.size() == 0) begin
					report_mismatch("report word arrived with none expected");
				end else begin
					want_rep = rmc_reports_q.pop_front();
					got_rep  = rmc_report_t'(m_axis_tdata);
					check_field("line_status", got_rep.line_status, want_rep.line_status);
					check_field("fix_valid", got_rep.fix_valid, want_rep.fix_valid);
					check_field("lat_high_chars", got_rep.lat_high_chars,
						want_rep.lat_high_chars);
					check_field("lat_low_chars", got_rep.lat_low_chars,
						want_rep.lat_low_chars);
					check_field("lat_length", got_rep.lat_length, want_rep.lat_length);
					check_field("lat_hemisphere", got_rep.lat_hemisphere,
						want_rep.lat_hemisphere);
					check_field("lon_high_chars", got_rep.lon_high_chars,
						want_rep.lon_high_chars);
					check_field("lon_low_chars", got_rep.lon_low_chars,
						want_rep.lon_low_chars);
					check_field("lon_length", got_rep.lon_length, want_rep.lon_length);
					check_field("lon_hemisphere", got_rep.lon_hemisphere,
						want_rep.lon_hemisphere);
					reports_checked++;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic push_char(input logic [7:0] ch);
		rx_bytes_q.push_back(ch);
		bytes_built++;
	endtask

	task automatic push_text(input string text);
		for (int i = 0; i < text.len(); i++)
			push_char(text[i]);
	endtask

	task automatic push_line(input string text);
		push_text(text);
		push_char(LINE_FEED);
	endtask

	function automatic logic [7:0] any_field_byte();
		logic [7:0] ch;
		do
			ch = 8'($urandom_range(255));
		while (ch == LINE_FEED || ch == COMMA);
		return ch;
	endfunction

	task automatic push_number(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				push_char(any_field_byte());
			else if ($urandom_range(7) == 0)
				push_char(8'h2E);
			else
				push_char(8'h30 + 8'($urandom_range(9)));
		end
	endtask

	task automatic push_letter(input logic [7:0] first_pick, input logic [7:0] second_pick);
		int r;
		r = $urandom_range(99);
		if (r < 40) begin
			push_char(first_pick);
		end else if (r < 75) begin
			push_char(second_pick);
		end else if (r < 83) begin
		end else if (r < 90) begin
			push_char(8'h00);
			push_char(first_pick);
		end else if (r < 95) begin
			push_char(any_field_byte());
		end else begin
			push_char(second_pick);
			push_char(first_pick);
		end
	endtask

	function automatic int coord_length();
		if ($urandom_range(99) < 10)
			return 14 + $urandom_range(6);
		return $urandom_range(11);
	endfunction

	task automatic push_rmc_line();
		int r;
		int commas;
		int bad_pos;
		r = $urandom_range(99);
		if (r < 8)
			commas = $urandom_range(10);
		else if (r < 94)
			commas = 11 + $urandom_range(3);
		else
			commas = 15 + $urandom_range(3);
		bad_pos = ($urandom_range(99) < 8) ? $urandom_range(5) : -1;
		for (int i = 0; i < 6; i++)
			push_char((i == bad_pos) ? any_field_byte() : 8'(RMC_HEADER[i]));
		for (int k = 1; k <= commas; k++) begin
			push_char(COMMA);
			case (k)
				FLD_STATUS: push_letter(STATUS_A, STATUS_V);
				FLD_LAT:    push_number(coord_length());
				FLD_NS:     push_letter(8'h4E, 8'h53);
				FLD_LON:    push_number(coord_length());
				FLD_EW:     push_letter(8'h45, 8'h57);
				default:    push_number($urandom_range(3));
			endcase
		end
		if ($urandom_range(1) == 1)
			push_char(CARRIAGE_RETURN);
		push_char(LINE_FEED);
	endtask

	task automatic push_random_phase(input int byte_goal, input int line_goal);
		int start_bytes;
		int lines;
		int r;
		start_bytes = bytes_built;
		lines       = 0;
		while (bytes_built - start_bytes < byte_goal || lines < line_goal) begin
			r = $urandom_range(99);
			if (r < 75) begin
				push_rmc_line();
			end else if (r < 88) begin
				for (int i = $urandom_range(24); i > 0; i--) begin
					push_char(8'($urandom_range(255)));
					if (rx_bytes_q[$] == LINE_FEED)
						lines++;
				end
				push_char(LINE_FEED);
			end else if (r < 96) begin
				push_text("$GPGGA,");
				push_number($urandom_range(8));
				push_char(LINE_FEED);
			end else begin
				push_char(LINE_FEED);
			end
			lines++;
		end
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (rx_bytes_q.size() != 0 || s_axis_tvalid || rmc_reports_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 35;
		recv_idle_pct = 52;
		push_line("");
		push_line("$GPRM");
		push_line("$GPRMX,,A,1,N,2,E,,,,,");
		push_line("$GPRMC,,A,1,N,2");
		push_text("$GPRMC,1,A,4807.038,N,01131.000,E,,,,,");
		push_char(CARRIAGE_RETURN);
		push_char(LINE_FEED);
		push_line("$GPRMC,,V,9,S,9,W,,,,,");
		push_line("$GPRMC,,X,9,S,9,W,,,,,");
		push_line("$GPRMC,,,9,S,9,W,,,,,");
		push_line("$GPRMC,,A,12345678901234567890,S,98765432109876543,W,,,,,");
		push_text("$GPRMC,,");
		push_char(8'h00);
		push_text("A,1,");
		push_char(8'h00);
		push_text("N,2,");
		push_char(8'h00);
		push_line("E,,,,,");
		push_text("$GPRMC,,A,");
		push_char(8'hFF);
		push_char(8'h80);
		push_char(8'h00);
		push_text(",");
		push_char(8'hFF);
		push_text(",");
		push_char(8'h7F);
		push_text(",");
		push_char(8'h01);
		push_line(",,,,,");
		push_line("$GPRMC,,A,,,,,,,,,");
		push_line("");
		push_line("");
		push_line("$GPRMC,,A,55,N,66,E,,,,,,,,,,,,,,,");
		push_line("$GPRMC,,AV,1,NS,2,EW,,,,,");
		wait_drained();

		push_random_phase(450, 25);
		wait_drained();

		send_idle_pct = 52;
		recv_idle_pct = 35;
		push_random_phase(450, 25);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		push_random_phase(500, 25);
		wait_drained();
		repeat (8) @(posedge clk);

		if (rmc_reports_q.size() != 0)
			report_mismatch($sformatf("%0d reports never arrived", rmc_reports_q.size()));
		$display("Drove %0d bytes; checked %0d reports (%0d fix, %0d void, %0d unknown status,",
			bytes_accepted, reports_checked, status_tally[RPT_FIX], status_tally[RPT_VOID],
			status_tally[RPT_UNKNOWN]);
		$display("%0d malformed, %0d other lines) with %0d mismatches.",
			status_tally[RPT_MALFORMED], status_tally[RPT_OTHER], mismatch_count);
		if (mismatch_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Run timed out with %0d reports outstanding.", rmc_reports_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
